// ===== src/gtm_pkg.sv =====
// Shared types, constants and elaboration-time helpers of the global tone mapper.
// No dependencies; every other file of the block but the request and result interfaces imports this package.
package gtm_pkg;

   // Default sizing of the block
   localparam int MAX_PIXELS_DEF     = 16777216;
   localparam int LOG_TABLE_BITS_DEF = 10;

   // Datapath widths
   localparam int XYZ_W       = 34;
   localparam int SUM_W       = 48;
   localparam int SCALE_W     = 32;
   localparam int DIV_W       = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_IDX_W   = 4;

   // Request codes
   localparam logic [1:0] REQ_ACCUM     = 2'd0;
   localparam logic [1:0] REQ_END_FRAME = 2'd1;
   localparam logic [1:0] REQ_MAP       = 2'd2;
   localparam logic [1:0] REQ_RESERVED  = 2'd3;

   // Result kinds
   localparam logic RESULT_PIXEL  = 1'b0;
   localparam logic RESULT_REPORT = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_VALUE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON   = 4'd1;

   localparam logic [15:0] KEY_RESET = 16'd737;
   localparam logic [15:0] EPS_RESET = 16'd1;

   // 0.0001 in Q24, added before the logarithm
   localparam logic [XYZ_W-1:0] LOG_BIAS = 34'd1678;

   // One queued item: request code plus the pixel in XYZ, Q24
   typedef struct packed {
      logic [1:0]       req_type;
      logic [XYZ_W-1:0] x;
      logic [XYZ_W-1:0] y;
      logic [XYZ_W-1:0] z;
   } gtm_item_type;

   // sRGB to XYZ, Q16
   localparam logic [15:0] TO_XYZ [3][3] = '{
      '{16'd27026, 16'd23435, 16'd11828},
      '{16'd13936, 16'd46869, 16'd4731},
      '{16'd1267,  16'd7812,  16'd62294}
   };

   // XYZ to sRGB, signed Q16
   localparam logic signed [18:0] TO_RGB [3][3] = '{
      '{ 19'sd212400, -19'sd100754, -19'sd32677},
      '{-19'sd63520,   19'sd122943,  19'sd2723},
      '{ 19'sd3646,   -19'sd13368,   19'sd69270}
   };

   // Integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] a);
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] rem;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      rem   = a;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q30, by repeated square roots starting from 2.0
   function automatic logic [30:0] root_q30(input int k);
      logic [63:0] root;
      root = 64'h8000_0000;
      for (int j = 1; j <= k; j++) begin
         root = isqrt64(root << 30);
      end
      return root[30:0];
   endfunction

endpackage

// ===== src/gtm_req_if.sv =====
// Request channel of the tone mapper: valid/ready plus the input item.
// Depends on nothing.
interface gtm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;

   modport source (output valid, req_type, red, green, blue, input ready);
   modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

// ===== src/gtm_rsp_if.sv =====
// Result channel of the tone mapper: valid/ready plus one result item.
// Depends on nothing.
interface gtm_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic [15:0] log_average_lum;

   modport source (output valid, result_kind, out_red, out_green, out_blue, log_average_lum,
                   input ready);
   modport sink   (input valid, result_kind, out_red, out_green, out_blue, log_average_lum,
                   output ready);
endinterface

// ===== src/gtm_csr_if.sv =====
// Register write channel of the tone mapper: valid/ready, index and data.
// Depends on gtm_pkg for the index width.
interface gtm_csr_if;
   import gtm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [15:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/gtm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on gtm_pkg for the operand width.
module gtm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gtm_pkg::DIV_W-1:0] dividend,
   input  logic [gtm_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [gtm_pkg::DIV_W-1:0] quotient
);
   import gtm_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] dsor_ff;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;
   logic [DIV_W-1:0] rem_in;
   logic [DIV_W-1:0] quo_in;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      diff   = trial - {1'b0, dsor_ff};
      fits   = (trial >= {1'b0, dsor_ff});
      rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_in = {quo_ff[DIV_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= dividend;
         dsor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== src/gtm_front.sv =====
// Front end: accepts requests, drops unused codes, converts pixels to XYZ.
// Depends on gtm_pkg and gtm_req_if.
module gtm_front (
   input  logic                  clock,
   input  logic                  reset,
   gtm_req_if.sink               req_in,
   output gtm_pkg::gtm_item_type item_out,
   output logic                  item_valid,
   input  logic                  item_ready
);
   import gtm_pkg::*;

   logic         stage_valid_ff;
   logic         stage_valid_in;
   gtm_item_type item_ff;
   gtm_item_type item_in;
   logic         accept;
   logic [XYZ_W-1:0] xyz [3];

   // Matrix product, exact in Q24
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         xyz[r] = XYZ_W'(TO_XYZ[r][0]) * XYZ_W'(req_in.red)
                + XYZ_W'(TO_XYZ[r][1]) * XYZ_W'(req_in.green)
                + XYZ_W'(TO_XYZ[r][2]) * XYZ_W'(req_in.blue);
      end
   end

   assign req_in.ready = !stage_valid_ff || item_ready;
   assign accept       = req_in.valid && req_in.ready;

   // Load the stage on a transfer; drop reserved codes
   always_comb begin
      item_in.req_type = req_in.req_type;
      item_in.x        = xyz[0];
      item_in.y        = xyz[1];
      item_in.z        = xyz[2];
      if (accept) begin
         stage_valid_in = (req_in.req_type != REQ_RESERVED);
      end else if (item_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_out   = item_ff;
   assign item_valid = stage_valid_ff;
endmodule

// ===== src/gtm_queue.sv =====
// Short FIFO between the front end and the back end.
// Depends on gtm_pkg for the item type and depth.
module gtm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  gtm_pkg::gtm_item_type in_item,
   input  logic                  in_valid,
   output logic                  in_ready,
   output gtm_pkg::gtm_item_type out_item,
   output logic                  out_valid,
   input  logic                  out_ready
);
   import gtm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   gtm_item_type     mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (push && !pop)      count_ff <= count_ff + (PTR_W+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end
endmodule

// ===== src/gtm_back.sv =====
// Back end: log-luminance accumulation, frame statistics and pixel mapping,
// sequenced over a shared divider. Depends on gtm_pkg, gtm_div, gtm_rsp_if.
module gtm_back #(
   parameter int MAX_PIXELS     = gtm_pkg::MAX_PIXELS_DEF,
   parameter int LOG_TABLE_BITS = gtm_pkg::LOG_TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gtm_pkg::gtm_item_type item_in,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  logic [15:0]           key_value,
   input  logic [15:0]           epsilon,
   gtm_rsp_if.source             rsp_out
);
   import gtm_pkg::*;

   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int LTB   = LOG_TABLE_BITS;
   localparam int IT_W  = $clog2(LTB);

   typedef enum logic [3:0] {
      S_IDLE, S_LOG_NORM, S_LOG_SQ, S_EF_DIV, S_EF_ROOT, S_EF_SDIV,
      S_MAP_XDIV, S_MAP_YDIV, S_MAP_MUL, S_MAP_DDIV, S_MAP_GUARD,
      S_MAP_XO, S_MAP_ZO, S_MAP_RGB, S_RESULT
   } state_type;

   // Roots 2^(2^-k) for k = 1 .. LTB
   logic [30:0] root_tab [LTB];
   for (genvar g = 0; g < LTB; g++) begin : g_root
      localparam logic [30:0] ROOT_VAL = root_q30(g + 1);
      assign root_tab[g] = ROOT_VAL;
   end

   state_type          state_ff, state_in;
   logic               go_ff, go_in;
   logic [XYZ_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [XYZ_W+1:0]   w_ff, w_in;
   logic [XYZ_W-1:0]   m_ff, m_in;
   logic [5:0]         p_ff, p_in;
   logic [31:0]        sq_ff, sq_in;
   logic [LTB-1:0]     frac_ff, frac_in;
   logic [IT_W-1:0]    iter_ff, iter_in;
   logic [SUM_W-1:0]   log_sum_ff, log_sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic signed [48:0] q_ff, q_in;
   logic signed [6:0]  n_ff, n_in;
   logic [30:0]        r_ff, r_in;
   logic [16:0]        x16_ff, x16_in, y16_ff, y16_in;
   logic [57:0]        prod_ff, prod_in;
   logic [15:0]        yc_ff, yc_in;
   logic [19:0]        xo_ff, xo_in, zo_ff, zo_in;
   logic signed [41:0] acc_ff, acc_in;
   logic [1:0]         row_ff, row_in, col_ff, col_in;
   logic               res_kind_ff, res_kind_in;
   logic [7:0]         res_r_ff, res_r_in, res_g_ff, res_g_in, res_b_ff, res_b_in;
   logic [15:0]        res_lal_ff, res_lal_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;
   logic [15:0]        rsp_lal_ff, rsp_lal_in;

   logic               div_start;
   logic [DIV_W-1:0]   div_dend;
   logic [DIV_W-1:0]   div_dsor;
   logic               div_done;
   logic [DIV_W-1:0]   div_quot;

   gtm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dend),
      .divisor  (div_dsor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Squaring step of the logarithm
   logic [61:0]      sq_prod;
   logic [31:0]      sq_t;
   logic [31:0]      sq_next;
   logic [LTB-1:0]   frac_next;
   logic [SUM_W-1:0] log_val;
   always_comb begin
      sq_prod   = 62'(sq_ff[30:0]) * 62'(sq_ff[30:0]);
      sq_t      = sq_prod[61:30];
      sq_next   = sq_t[31] ? {1'b0, sq_t[31:1]} : sq_t;
      frac_next = {frac_ff[LTB-2:0], sq_t[31]};
      log_val   = ((SUM_W'(p_ff) - SUM_W'(24)) << LTB) + SUM_W'(frac_next);
   end

   // Mean of the log sum, rounded toward minus infinity
   logic             sum_neg;
   logic [SUM_W-1:0] sum_mag;
   logic [DIV_W-1:0] ef_dend;
   always_comb begin
      sum_neg = log_sum_ff[SUM_W-1];
      sum_mag = sum_neg ? (~log_sum_ff + SUM_W'(1)) : log_sum_ff;
      ef_dend = sum_neg ? (DIV_W'(sum_mag) + DIV_W'(count_ff) - DIV_W'(1)) : DIV_W'(sum_mag);
   end

   // Exponent clamp, root product, report and scale
   logic signed [48:0] n_full;
   logic [LTB-1:0]     f_bits;
   logic               f_bit;
   logic [62:0]        rr;
   logic [5:0]         lal_sh;
   logic [30:0]        lal_w;
   logic [15:0]        lal;
   logic [DIV_W-1:0]   sc_dsor;
   logic [4:0]         neg_sh;
   logic [47:0]        sc_w;
   logic [SCALE_W-1:0] sc;
   always_comb begin
      n_full = q_ff >>> LTB;
      if (n_full < -49'sd24)      n_in = -7'sd24;
      else if (n_full > 49'sd20)  n_in = 7'sd20;
      else                        n_in = n_full[6:0];
      f_bits = q_ff[LTB-1:0];
      f_bit  = f_bits[IT_W'(LTB - 1) - iter_ff];
      rr     = 63'(r_ff) * 63'(root_tab[iter_ff]) + 63'(32'h2000_0000);
      lal_sh = 6'(7'sd22 - n_ff);
      lal_w  = r_ff >> lal_sh;
      lal    = (|lal_w[30:16]) ? 16'hFFFF : lal_w[15:0];
      sc_dsor = (n_ff >= 7'sd0) ? (DIV_W'(r_ff) << n_ff[4:0]) : DIV_W'(r_ff);
      neg_sh  = (n_ff < 7'sd0) ? 5'(-n_ff) : 5'd0;
      sc_w    = 48'(div_quot[19:0]) << neg_sh;
      sc      = (|sc_w[47:32]) ? '1 : sc_w[31:0];
   end

   // Color matrix step and 8-bit clamp
   logic signed [41:0] coef_w;
   logic signed [41:0] v_w;
   logic [19:0]        v_sel;
   logic signed [41:0] acc_next;
   logic [39:0]        c40;
   logic [7:0]         chan;
   logic               guard_ok;
   logic [XYZ_W+1:0]   item_w;
   always_comb begin
      unique case (col_ff)
         2'd0:    v_sel = xo_ff;
         2'd1:    v_sel = 20'(yc_ff);
         default: v_sel = zo_ff;
      endcase
      coef_w   = 42'(TO_RGB[row_ff][col_ff]);
      v_w      = 42'(signed'({1'b0, v_sel}));
      acc_next = acc_ff + coef_w * v_w;
      c40      = 40'(acc_next[31:0]) * 40'd255;
      if (acc_next[41] || acc_next == '0)  chan = 8'd0;
      else if (|acc_next[40:32])           chan = 8'd255;
      else                                 chan = c40[39:32];
      guard_ok = (yc_ff > epsilon) && (x16_ff > 17'(epsilon)) && (y16_ff > 17'(epsilon))
                 && (y_ff != '0);
      item_w   = (XYZ_W+2)'(item_in.x) + (XYZ_W+2)'(item_in.y) + (XYZ_W+2)'(item_in.z);
   end

   // Divider operands by state
   always_comb begin
      unique case (state_ff)
         S_EF_DIV: begin
            div_dend = ef_dend;
            div_dsor = DIV_W'(count_ff);
         end
         S_EF_SDIV: begin
            div_dend = DIV_W'({key_value, 34'd0});
            div_dsor = sc_dsor;
         end
         S_MAP_XDIV: begin
            div_dend = DIV_W'({x_ff, 16'd0});
            div_dsor = DIV_W'(w_ff);
         end
         S_MAP_YDIV: begin
            div_dend = DIV_W'({y_ff, 16'd0});
            div_dsor = DIV_W'(w_ff);
         end
         S_MAP_DDIV: begin
            div_dend = DIV_W'(prod_ff) + DIV_W'(64'h0001_0000_FFFF_FFFF);
            div_dsor = DIV_W'(prod_ff) + DIV_W'(64'h1_0000_0000);
         end
         S_MAP_XO: begin
            div_dend = DIV_W'(50'(yc_ff) * 50'(x_ff));
            div_dsor = DIV_W'(y_ff);
         end
         S_MAP_ZO: begin
            div_dend = DIV_W'(50'(yc_ff) * 50'(z_ff));
            div_dsor = DIV_W'(y_ff);
         end
         default: begin
            div_dend = '0;
            div_dsor = '0;
         end
      endcase
   end

   assign item_ready = (state_ff == S_IDLE);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      go_in       = go_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      w_in        = w_ff;
      m_in        = m_ff;
      p_in        = p_ff;
      sq_in       = sq_ff;
      frac_in     = frac_ff;
      iter_in     = iter_ff;
      log_sum_in  = log_sum_ff;
      count_in    = count_ff;
      scale_in    = scale_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      x16_in      = x16_ff;
      y16_in      = y16_ff;
      prod_in     = prod_ff;
      yc_in       = yc_ff;
      xo_in       = xo_ff;
      zo_in       = zo_ff;
      acc_in      = acc_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      res_kind_in = res_kind_ff;
      res_r_in    = res_r_ff;
      res_g_in    = res_g_ff;
      res_b_in    = res_b_ff;
      res_lal_in  = res_lal_ff;
      div_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_out.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_r_in    = rsp_r_ff;
      rsp_g_in    = rsp_g_ff;
      rsp_b_in    = rsp_b_ff;
      rsp_lal_in  = rsp_lal_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               x_in = item_in.x;
               y_in = item_in.y;
               z_in = item_in.z;
               w_in = item_w;
               unique case (item_in.req_type)
                  REQ_ACCUM: begin
                     // drop pixels past the counter limit
                     if (count_ff < CNT_W'(MAX_PIXELS)) begin
                        m_in     = item_in.y + LOG_BIAS;
                        p_in     = 6'd33;
                        state_in = S_LOG_NORM;
                     end
                  end
                  REQ_END_FRAME: begin
                     res_kind_in = RESULT_REPORT;
                     res_r_in    = '0;
                     res_g_in    = '0;
                     res_b_in    = '0;
                     if (count_ff == '0) begin
                        // empty frame: unity luminance
                        scale_in   = SCALE_W'({key_value, 4'd0});
                        res_lal_in = 16'd256;
                        log_sum_in = '0;
                        state_in   = S_RESULT;
                     end else begin
                        state_in = S_EF_DIV;
                     end
                  end
                  REQ_MAP: begin
                     res_kind_in = RESULT_PIXEL;
                     res_lal_in  = '0;
                     if (item_w == '0) begin
                        x16_in   = '0;
                        y16_in   = '0;
                        state_in = S_MAP_MUL;
                     end else begin
                        state_in = S_MAP_XDIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOG_NORM: begin
            if (m_ff[XYZ_W-1]) begin
               sq_in    = {1'b0, m_ff[XYZ_W-1:3]};
               frac_in  = '0;
               iter_in  = '0;
               state_in = S_LOG_SQ;
            end else begin
               m_in = m_ff << 1;
               p_in = p_ff - 6'd1;
            end
         end
         S_LOG_SQ: begin
            sq_in   = sq_next;
            frac_in = frac_next;
            iter_in = iter_ff + IT_W'(1);
            if (iter_ff == IT_W'(LTB - 1)) begin
               log_sum_in = log_sum_ff + log_val;
               count_in   = count_ff + CNT_W'(1);
               state_in   = S_IDLE;
            end
         end
         S_EF_DIV: begin
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               q_in     = sum_neg ? (49'sd0 - signed'(div_quot[48:0]))
                                  : signed'(div_quot[48:0]);
               r_in     = 31'h4000_0000;
               iter_in  = '0;
               state_in = S_EF_ROOT;
            end
         end
         S_EF_ROOT: begin
            if (f_bit) r_in = rr[60:30];
            iter_in = iter_ff + IT_W'(1);
            if (iter_ff == IT_W'(LTB - 1)) state_in = S_EF_SDIV;
         end
         S_EF_SDIV: begin
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in      = 1'b0;
               scale_in   = sc;
               res_lal_in = lal;
               log_sum_in = '0;
               count_in   = '0;
               state_in   = S_RESULT;
            end
         end
         S_MAP_XDIV: begin
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               x16_in   = div_quot[16:0];
               state_in = S_MAP_YDIV;
            end
         end
         S_MAP_YDIV: begin
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               y16_in   = div_quot[16:0];
               state_in = S_MAP_MUL;
            end
         end
         S_MAP_MUL: begin
            prod_in  = 58'(y_ff[XYZ_W-1:8]) * 58'(scale_ff);
            state_in = S_MAP_DDIV;
         end
         S_MAP_DDIV: begin
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               yc_in    = 16'(17'h1_0000 - div_quot[16:0]);
               state_in = S_MAP_GUARD;
            end
         end
         S_MAP_GUARD: begin
            acc_in = '0;
            row_in = '0;
            col_in = '0;
            if (guard_ok) begin
               state_in = S_MAP_XO;
            end else begin
               // degenerate chromaticity: fall back to epsilon
               xo_in    = 20'(epsilon);
               zo_in    = 20'(epsilon);
               state_in = S_MAP_RGB;
            end
         end
         S_MAP_XO: begin
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               xo_in    = div_quot[19:0];
               state_in = S_MAP_ZO;
            end
         end
         S_MAP_ZO: begin
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               zo_in    = div_quot[19:0];
               state_in = S_MAP_RGB;
            end
         end
         S_MAP_RGB: begin
            if (col_ff == 2'd2) begin
               unique case (row_ff)
                  2'd0:    res_r_in = chan;
                  2'd1:    res_g_in = chan;
                  default: res_b_in = chan;
               endcase
               acc_in = '0;
               col_in = '0;
               row_in = row_ff + 2'd1;
               if (row_ff == 2'd2) state_in = S_RESULT;
            end else begin
               acc_in = acc_next;
               col_in = col_ff + 2'd1;
            end
         end
         S_RESULT: begin
            // hand off to the output register once it frees up
            if (!rsp_valid_ff || rsp_out.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_r_in     = res_r_ff;
               rsp_g_in     = res_g_ff;
               rsp_b_in     = res_b_ff;
               rsp_lal_in   = res_lal_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         log_sum_ff   <= '0;
         count_ff     <= '0;
         scale_ff     <= SCALE_W'({KEY_RESET, 4'd0});
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         log_sum_ff   <= log_sum_in;
         count_ff     <= count_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         z_ff        <= z_in;
         w_ff        <= w_in;
         m_ff        <= m_in;
         p_ff        <= p_in;
         sq_ff       <= sq_in;
         frac_ff     <= frac_in;
         iter_ff     <= iter_in;
         q_ff        <= q_in;
         n_ff        <= (state_ff == S_EF_ROOT) ? n_in : n_ff;
         r_ff        <= r_in;
         x16_ff      <= x16_in;
         y16_ff      <= y16_in;
         prod_ff     <= prod_in;
         yc_ff       <= yc_in;
         xo_ff       <= xo_in;
         zo_ff       <= zo_in;
         acc_ff      <= acc_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         res_kind_ff <= res_kind_in;
         res_r_ff    <= res_r_in;
         res_g_ff    <= res_g_in;
         res_b_ff    <= res_b_in;
         res_lal_ff  <= res_lal_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_r_ff    <= rsp_r_in;
         rsp_g_ff    <= rsp_g_in;
         rsp_b_ff    <= rsp_b_in;
         rsp_lal_ff  <= rsp_lal_in;
      end
   end

   assign rsp_out.valid           = rsp_valid_ff;
   assign rsp_out.result_kind     = rsp_kind_ff;
   assign rsp_out.out_red         = rsp_r_ff;
   assign rsp_out.out_green       = rsp_g_ff;
   assign rsp_out.out_blue        = rsp_b_ff;
   assign rsp_out.log_average_lum = rsp_lal_ff;
endmodule

// ===== src/global_tone_mapper.sv =====
// Global tone mapper: front end, item queue, back end and control registers.
// Back end: accumulate normalizes, then runs LOG_TABLE_BITS squarings; end of frame and map
// divide on the shared divider, except for an empty frame, for x and y of a black pixel and
// for X and Z when the guard trips. The front end takes one item per cycle, while the queue
// has room, into a four-entry queue ahead of the back end. Synchronous reset clears the
// statistics, sets the scale to key/1.0 and loads defaults.
module global_tone_mapper #(
   parameter int MAX_PIXELS     = gtm_pkg::MAX_PIXELS_DEF,
   parameter int LOG_TABLE_BITS = gtm_pkg::LOG_TABLE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   gtm_req_if.sink   req_in,
   gtm_rsp_if.source rsp_out,
   gtm_csr_if.sink   csr_in
);
   import gtm_pkg::*;

   logic [15:0]  key_ff;
   logic [15:0]  eps_ff;
   gtm_item_type f_item;
   logic         f_valid;
   logic         f_ready;
   gtm_item_type q_item;
   logic         q_valid;
   logic         q_ready;

   // Register writes are always taken
   assign csr_in.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
         eps_ff <= EPS_RESET;
      end else if (csr_in.valid) begin
         if (csr_in.index == CSR_KEY_VALUE) key_ff <= csr_in.data;
         if (csr_in.index == CSR_EPSILON)   eps_ff <= csr_in.data;
      end
   end

   gtm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_in     (req_in),
      .item_out   (f_item),
      .item_valid (f_valid),
      .item_ready (f_ready)
   );

   gtm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (f_item),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .out_item  (q_item),
      .out_valid (q_valid),
      .out_ready (q_ready)
   );

   gtm_back #(
      .MAX_PIXELS     (MAX_PIXELS),
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_in    (q_item),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .key_value  (key_ff),
      .epsilon    (eps_ff),
      .rsp_out    (rsp_out)
   );

   // Reserved codes never reach the queue
   a_no_reserved: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> q_item.req_type != REQ_RESERVED)
      else $error("reserved request in queue");

   // Pixel results carry no luminance report
   a_pixel_lal: assert property (@(posedge clock) disable iff (reset)
      rsp_out.valid && rsp_out.result_kind == RESULT_PIXEL |-> rsp_out.log_average_lum == '0)
      else $error("pixel result with luminance");

   // Reports carry no color
   a_report_rgb: assert property (@(posedge clock) disable iff (reset)
      rsp_out.valid && rsp_out.result_kind == RESULT_REPORT
      |-> rsp_out.out_red == '0 && rsp_out.out_green == '0 && rsp_out.out_blue == '0)
      else $error("report with color");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_out.valid)
      else $error("result valid after reset");
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for global_tone_mapper: random and directed frames,
// with its own fixed-point predictor. Depends on gtm_pkg and the three channel interfaces.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gtm_pkg::*;

   localparam int LOG_BITS   = 10;
   localparam int PIX_LIMIT  = 16777216;
   localparam int SETTLE     = 400;
   localparam longint LIMIT  = 3000000;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } pixel_req_type;

   typedef struct {
      logic        kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] lal;
   } tone_out_type;

   localparam longint unsigned XYZ_COEF [3][3] = '{
      '{27026, 23435, 11828}, '{13936, 46869, 4731}, '{1267, 7812, 62294}};
   localparam longint RGB_COEF [3][3] = '{
      '{212400, -100754, -32677}, '{-63520, 122943, 2723}, '{3646, -13368, 69270}};

   logic clock;
   logic reset;
   gtm_req_if req ();
   gtm_rsp_if rsp ();
   gtm_csr_if csr ();

   global_tone_mapper #(.MAX_PIXELS(PIX_LIMIT), .LOG_TABLE_BITS(LOG_BITS)) uut (
      .clock(clock), .reset(reset), .req_in(req), .rsp_out(rsp), .csr_in(csr));

   // predictor state
   logic [15:0]        key_reg;
   logic [15:0]        eps_reg;
   logic signed [47:0] frame_log_sum;
   longint unsigned    frame_pixels;
   longint unsigned    scale_q16;
   longint unsigned    half_roots [1:LOG_BITS];

   pixel_req_type pending_pixels[$];
   tone_out_type  expected_tones[$];
   int         fail_count;
   int         req_gap;
   int         stall_left;
   int         hold_left;
   bit         req_taken;
   longint     cycle_count;
   int         n_accum, n_frames, n_maps, n_ignored, n_checked;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned a);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > a) b >>= 2;
      while (b != 0) begin
         if (a >= res + b) begin
            a -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint div_down(longint a, longint b);
      if (a >= 0) return a / b;
      return -((-a + b - 1) / b);
   endfunction

   function automatic void to_xyz(input pixel_req_type p, output longint unsigned xyz [3]);
      for (int i = 0; i < 3; i++)
         xyz[i] = XYZ_COEF[i][0] * p.red + XYZ_COEF[i][1] * p.green
                + XYZ_COEF[i][2] * p.blue;
   endfunction

   // log2 with LOG_BITS fraction bits, by repeated squaring
   function automatic longint log2_q(longint unsigned v);
      int p;
      longint unsigned t, m;
      longint frac;
      p = 0;
      t = v;
      frac = 0;
      while (t > 1) begin
         t >>= 1;
         p++;
      end
      m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      for (int i = 0; i < LOG_BITS; i++) begin
         m = (m * m) >> 30;
         frac *= 2;
         if (m >= (64'd1 << 31)) begin
            m >>= 1;
            frac += 1;
         end
      end
      return longint'(p - 24) * (64'sd1 <<< LOG_BITS) + frac;
   endfunction

   function automatic logic [7:0] clamp8(longint c);
      if (c <= 0) return 8'd0;
      if (c >= (64'sd1 <<< 32)) return 8'd255;
      return 8'((longint'(c) * 255) >>> 32);
   endfunction

   // advance the predictor by one transfer; returns 1 when a result is due
   function automatic bit tone_predict(input pixel_req_type p, output tone_out_type o);
      longint unsigned xyz [3];
      longint unsigned w, x16, y16, yv, prod, den, yc, xo, zo, r, num, sc, lal;
      longint s, q, n, f, c;
      longint unsigned v [3];
      o = '{default: '0};
      case (p.kind)
         REQ_ACCUM: begin
            if (frame_pixels < PIX_LIMIT) begin
               to_xyz(p, xyz);
               frame_log_sum = frame_log_sum + 48'(log2_q(xyz[1] + 1678));
               frame_pixels++;
            end
            n_accum++;
            return 0;
         end
         REQ_END_FRAME: begin
            if (frame_pixels == 0) begin
               sc = 64'(key_reg) << 4;
               lal = 256;
            end else begin
               r = 64'd1 << 30;
               num = 64'(key_reg) << 34;
               s = longint'(frame_log_sum);
               q = div_down(s, longint'(frame_pixels));
               n = div_down(q, 64'sd1 <<< LOG_BITS);
               f = q - n * (64'sd1 <<< LOG_BITS);
               for (int k = 1; k <= LOG_BITS; k++)
                  if ((f >> (LOG_BITS - k)) & 1)
                     r = (r * half_roots[k] + (64'd1 << 29)) >> 30;
               if (n < -24) n = -24;
               if (n > 20) n = 20;
               lal = r >> (22 - n);
               if (lal > 16'hFFFF) lal = 16'hFFFF;
               if (n >= 0) sc = num / (r << n);
               else sc = (num / r) << (-n);
               if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
            end
            scale_q16 = sc;
            frame_log_sum = '0;
            frame_pixels = 0;
            o.kind = RESULT_REPORT;
            o.lal = 16'(lal);
            n_frames++;
            return 1;
         end
         REQ_MAP: begin
            to_xyz(p, xyz);
            w = xyz[0] + xyz[1] + xyz[2];
            x16 = 0;
            y16 = 0;
            yv = 0;
            if (w != 0) begin
               x16 = (xyz[0] << 16) / w;
               y16 = (xyz[1] << 16) / w;
               yv = xyz[1] >> 8;
            end
            prod = yv * scale_q16;
            den = prod + (64'd1 << 32);
            yc = 65536 - ((64'd1 << 48) + den - 1) / den;
            if (yc > eps_reg && x16 > eps_reg && y16 > eps_reg && xyz[1] != 0) begin
               xo = yc * xyz[0] / xyz[1];
               zo = yc * xyz[2] / xyz[1];
            end else begin
               xo = eps_reg;
               zo = eps_reg;
            end
            v[0] = xo;
            v[1] = yc;
            v[2] = zo;
            o.kind = RESULT_PIXEL;
            c = RGB_COEF[0][0] * longint'(v[0]) + RGB_COEF[0][1] * longint'(v[1])
              + RGB_COEF[0][2] * longint'(v[2]);
            o.red = clamp8(c);
            c = RGB_COEF[1][0] * longint'(v[0]) + RGB_COEF[1][1] * longint'(v[1])
              + RGB_COEF[1][2] * longint'(v[2]);
            o.green = clamp8(c);
            c = RGB_COEF[2][0] * longint'(v[0]) + RGB_COEF[2][1] * longint'(v[1])
              + RGB_COEF[2][2] * longint'(v[2]);
            o.blue = clamp8(c);
            n_maps++;
            return 1;
         end
         default: begin
            n_ignored++;
            return 0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
      fail_count++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver: change inputs on the falling edge
   always @(negedge clock) begin
      pixel_req_type cur;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            cur = pending_pixels.pop_front();
            req.valid <= 1'b1;
            req.req_type <= cur.kind;
            req.red <= cur.red;
            req.green <= cur.green;
            req.blue <= cur.blue;
            req_gap = pick_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // input transfer: run the predictor
   always @(posedge clock) begin
      pixel_req_type p;
      tone_out_type o;
      req_taken = !reset && req.valid && req.ready;
      if (req_taken) begin
         p.kind = req.req_type;
         p.red = req.red;
         p.green = req.green;
         p.blue = req.blue;
         if (tone_predict(p, o)) expected_tones.push_back(o);
      end
   end

   // result sink: random stalls plus a long hold on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // result monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      tone_out_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_tones.size() == 0) begin
            report_mismatch("unexpected result, kind", rsp.result_kind, -1);
         end else begin
            want = expected_tones.pop_front();
            n_checked++;
            if (rsp.result_kind !== want.kind)
               report_mismatch("result_kind", rsp.result_kind, want.kind);
            if (rsp.out_red !== want.red) report_mismatch("out_red", rsp.out_red, want.red);
            if (rsp.out_green !== want.green)
               report_mismatch("out_green", rsp.out_green, want.green);
            if (rsp.out_blue !== want.blue)
               report_mismatch("out_blue", rsp.out_blue, want.blue);
            if (rsp.log_average_lum !== want.lal)
               report_mismatch("log_average_lum", rsp.log_average_lum, want.lal);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_tones.size());
         $display("global_tone_mapper verification failed");
         $finish;
      end
   end

   function automatic logic [15:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 255));
         3: return 16'($urandom_range(0, 4095));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_px(input logic [1:0] kind, input logic [15:0] r, g, b);
      pixel_req_type p;
      p.kind = kind;
      p.red = r;
      p.green = g;
      p.blue = b;
      pending_pixels.push_back(p);
   endtask

   task automatic push_rand(input logic [1:0] kind);
      push_px(kind, rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      if (idx == CSR_KEY_VALUE) key_reg = value;
      else if (idx == CSR_EPSILON) eps_reg = value;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // hold the sender until every prediction is matched, then let accumulates finish
   task automatic drain();
      while (pending_pixels.size() > 0 || req.valid || expected_tones.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // well-formed frames with random content, plus some noise
   task automatic random_phase(input int count);
      int made, acc;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) == 0) begin
            push_px(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom));
            made++;
         end else begin
            acc = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            repeat (acc) push_rand(REQ_ACCUM);
            push_rand(REQ_END_FRAME);
            made += acc + 1;
            repeat ($urandom_range(1, 8)) begin
               push_rand(REQ_MAP);
               made++;
            end
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.req_type = REQ_ACCUM;
      req.red = '0;
      req.green = '0;
      req.blue = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = CSR_KEY_VALUE;
      csr.data = '0;
      key_reg = KEY_RESET;
      eps_reg = EPS_RESET;
      frame_log_sum = '0;
      frame_pixels = 0;
      scale_q16 = 64'(KEY_RESET) << 4;
      fail_count = 0;
      req_gap = 0;
      stall_left = 0;
      hold_left = 0;
      req_taken = 0;
      cycle_count = 0;
      n_accum = 0;
      n_frames = 0;
      n_maps = 0;
      n_ignored = 0;
      n_checked = 0;
      half_roots[1] = int_sqrt(64'd2 << 60);
      for (int k = 2; k <= LOG_BITS; k++) half_roots[k] = int_sqrt(half_roots[k-1] << 30);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: maps at the reset scale, empty frame, field extremes, ignored code
      push_px(REQ_MAP, 16'h0000, 16'h0000, 16'h0000);
      push_px(REQ_MAP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_px(REQ_END_FRAME, 16'h0000, 16'h0000, 16'h0000);
      push_px(REQ_ACCUM, 16'h0000, 16'h0000, 16'h0000);
      push_px(REQ_ACCUM, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_px(REQ_ACCUM, 16'hFFFF, 16'h0000, 16'h0000);
      push_px(REQ_ACCUM, 16'h0000, 16'hFFFF, 16'h0000);
      push_px(REQ_ACCUM, 16'h0000, 16'h0000, 16'hFFFF);
      push_px(REQ_RESERVED, 16'hFFFF, 16'hAAAA, 16'h5555);
      push_px(REQ_END_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_px(REQ_MAP, 16'h0000, 16'h0000, 16'h0000);
      push_px(REQ_MAP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_px(REQ_MAP, 16'hFFFF, 16'h0000, 16'h0000);
      push_px(REQ_MAP, 16'h0000, 16'hFFFF, 16'h0000);
      push_px(REQ_MAP, 16'h0000, 16'h0000, 16'hFFFF);
      push_px(REQ_MAP, 16'h0001, 16'h0000, 16'h0000);
      push_px(REQ_MAP, 16'h0100, 16'h0100, 16'h0100);
      push_px(REQ_ACCUM, 16'h0001, 16'h0001, 16'h0001);
      push_px(REQ_END_FRAME, 16'h0000, 16'h0000, 16'h0000);
      push_px(REQ_MAP, 16'h0100, 16'h0080, 16'h0040);
      push_px(REQ_END_FRAME, 16'h1234, 16'h0000, 16'h0000);
      push_px(REQ_MAP, 16'h00FF, 16'h00FF, 16'h00FF);
      drain();

      // key change takes effect only at the next end of frame
      csr_write(CSR_KEY_VALUE, 16'hFFFF);
      push_px(REQ_MAP, 16'h0100, 16'h0100, 16'h0100);
      push_px(REQ_END_FRAME, 16'h0000, 16'h0000, 16'h0000);
      push_px(REQ_MAP, 16'h0100, 16'h0100, 16'h0100);
      drain();

      // long receiver hold while the sender keeps offering
      hold_left = 600;
      random_phase(120);
      drain();

      csr_write(CSR_KEY_VALUE, 16'h0000);
      csr_write(CSR_EPSILON, 16'h0000);
      random_phase(110);
      drain();

      csr_write(CSR_KEY_VALUE, 16'hFFFF);
      csr_write(CSR_EPSILON, 16'hFFFF);
      random_phase(110);
      drain();

      csr_write(CSR_EPSILON, 16'h8000);
      csr_write(CSR_KEY_VALUE, 16'h1000);
      random_phase(110);
      drain();

      csr_write(CSR_KEY_VALUE, KEY_RESET);
      csr_write(CSR_EPSILON, 16'h0100);
      random_phase(110);
      drain();

      repeat (4) begin
         csr_write(CSR_KEY_VALUE, 16'($urandom));
         csr_write(CSR_EPSILON, 16'($urandom_range(0, 3000)));
         random_phase(110);
         drain();
      end

      $display("Covered %0d accumulates, %0d frame ends, %0d maps, %0d ignored requests;",
               n_accum, n_frames, n_maps, n_ignored);
      $display("%0d results compared across key and epsilon extremes.", n_checked);
      if (fail_count == 0) begin
         $display("global_tone_mapper verification clean");
      end else begin
         $display("global_tone_mapper verification failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/gtm_pkg.sv
src/gtm_req_if.sv
src/gtm_rsp_if.sv
src/gtm_csr_if.sv
src/gtm_div.sv
src/gtm_front.sv
src/gtm_queue.sv
src/gtm_back.sv
src/global_tone_mapper.sv
bench/testbench.sv
